@@ rtl/core/vtra_pkg.sv @@
// ---------------------------------------------------------------------------
// vtra_pkg: shared definitions for the vector table range allocator
// Request codes, register indexes, field widths and search constants.
// ---------------------------------------------------------------------------
`default_nettype none

package vtra_pkg;

   // field widths of the request and response beats
   localparam int unsigned IDX_W  = 9;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned RUN_W  = 6;
   localparam int unsigned TYPE_W = 2;

   // packed beat widths, rounded up to whole bytes
   localparam int unsigned REQ_DATA_W = 144;
   localparam int unsigned RSP_DATA_W = 144;

   // range search constants
   localparam int unsigned SEARCH_START = 32;
   localparam int unsigned MAX_RUN      = 32;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_ASSIGN  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_GET     = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RESERVE = 2'd2;

   // configuration register indexes
   localparam logic CSR_FREE_MARKER     = 1'b0;
   localparam logic CSR_RESERVED_MARKER = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/vector_table_range_allocator_unit.sv @@
// ---------------------------------------------------------------------------
// vector_table_range_allocator_unit: interrupt vector table with range search
// Holds handler and state words per vector; serves assign, get and reserve.
// ---------------------------------------------------------------------------
// Usage
//   req_* carries one request per beat, the kind in req_tuser. Every request
//   gives exactly one response beat on rsp_*. csr_* writes the free marker
//   (index 0) and reserved marker (index 1); the user must do so only while
//   no request is in flight, and nothing in the block enforces this.
// Sequencing
//   One request is worked on at a time. Assign and a rejected request go
//   straight to S_OUT; get passes S_GET for the synchronous table read.
//   Reserve walks the handler memory one entry at a time (read, then
//   compare) from vector 32, then writes the found run one entry per cycle.
// Reset and stalls
//   Reset clears the control state and both markers; table contents are
//   undefined until written. The response sits in an output register, so a
//   new request is taken while it waits; a finished result behind a stalled
//   response waits until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_table_range_allocator_unit
   import vtra_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 256
) (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // entry_index[8:0], new_handler[72:9], new_state[136:73],
   // run_length[142:137], aligned_step[143]
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  wire  [TYPE_W-1:0]     req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // status[0], read_handler[64:1], read_state[128:65], first_index[137:129],
   // zero fill[143:138]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  wire                   csr_we,
   input  wire                   csr_addr,
   input  wire  [WORD_W-1:0]     csr_wdata
);

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam int unsigned BW = AW + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GET,
      S_RD,
      S_CMP,
      S_MARK,
      S_OUT
   } state_type;

   state_type state_ff;

   // request fields
   logic [IDX_W-1:0]  req_entry_index;
   logic [WORD_W-1:0] req_new_handler;
   logic [WORD_W-1:0] req_new_state;
   logic [RUN_W-1:0]  req_run_length;
   logic              req_aligned_step;

   assign req_entry_index  = req_tdata[8:0];
   assign req_new_handler  = req_tdata[72:9];
   assign req_new_state    = req_tdata[136:73];
   assign req_run_length   = req_tdata[142:137];
   assign req_aligned_step = req_tdata[143];

   // configuration registers
   logic [WORD_W-1:0] free_marker_ff;
   logic [WORD_W-1:0] reserved_marker_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_marker_ff     <= '0;
         reserved_marker_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FREE_MARKER:     free_marker_ff     <= csr_wdata;
            CSR_RESERVED_MARKER: reserved_marker_ff <= csr_wdata;
            default:             free_marker_ff     <= free_marker_ff;
         endcase
      end
   end

   // search registers
   logic [BW-1:0]    base_ff;
   logic [RUN_W-1:0] cnt_ff;
   logic [RUN_W-1:0] n_ff;
   logic             aligned_ff;

   // result holding registers
   logic              res_status_ff;
   logic [WORD_W-1:0] res_handler_ff;
   logic [WORD_W-1:0] res_state_ff;
   logic [IDX_W-1:0]  res_first_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // memory read data
   logic [WORD_W-1:0] rd_handler_ff;
   logic [WORD_W-1:0] rd_state_ff;

   // handshake and decode
   logic req_fire;
   logic out_free;
   logic idx_in_range;
   logic run_ok;

   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign idx_in_range = ({1'b0, req_entry_index} < (IDX_W+1)'(TABLE_ENTRIES));
   assign run_ok       = (req_run_length != '0)
                      && (req_run_length <= RUN_W'(MAX_RUN));

   // scan position and bound check
   logic [BW-1:0] scan_pos;
   logic          scan_fits;
   logic          entry_free;

   assign scan_pos   = base_ff + BW'(cnt_ff);
   assign scan_fits  = (base_ff + BW'(n_ff)) <= BW'(TABLE_ENTRIES);
   assign entry_free = (rd_handler_ff == free_marker_ff);

   // memory port controls
   logic              mem_we_in;
   logic              state_we_in;
   logic [AW-1:0]     mem_waddr_in;
   logic [WORD_W-1:0] mem_whandler_in;
   logic [AW-1:0]     mem_raddr_in;

   always_comb begin
      mem_we_in       = 1'b0;
      state_we_in     = 1'b0;
      mem_waddr_in    = scan_pos[AW-1:0];
      mem_whandler_in = reserved_marker_ff;
      mem_raddr_in    = scan_pos[AW-1:0];
      if (state_ff == S_IDLE) begin
         mem_waddr_in    = req_entry_index[AW-1:0];
         mem_whandler_in = req_new_handler;
         mem_raddr_in    = req_entry_index[AW-1:0];
         if (req_fire && req_tuser == REQ_ASSIGN && idx_in_range
             && req_new_handler != '0) begin
            mem_we_in   = 1'b1;
            state_we_in = 1'b1;
         end
      end else if (state_ff == S_MARK) begin
         mem_we_in = 1'b1;
      end
   end

   // handler and state memories
   logic [WORD_W-1:0] handler_mem [TABLE_ENTRIES];
   logic [WORD_W-1:0] state_mem   [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (mem_we_in) begin
         handler_mem[mem_waddr_in] <= mem_whandler_in;
      end
      rd_handler_ff <= handler_mem[mem_raddr_in];
   end

   always_ff @(posedge clock) begin
      if (state_we_in) begin
         state_mem[mem_waddr_in] <= req_new_state;
      end
      rd_state_ff <= state_mem[mem_raddr_in];
   end

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  res_handler_ff <= '0;
                  res_state_ff   <= '0;
                  res_first_ff   <= '0;
                  base_ff        <= BW'(SEARCH_START);
                  cnt_ff         <= '0;
                  n_ff           <= req_run_length;
                  aligned_ff     <= req_aligned_step;
                  case (req_tuser)
                     REQ_ASSIGN: begin
                        res_status_ff <= !(idx_in_range && req_new_handler != '0);
                        state_ff      <= S_OUT;
                     end
                     REQ_GET: begin
                        res_status_ff <= 1'b1;
                        state_ff      <= idx_in_range ? S_GET : S_OUT;
                     end
                     REQ_RESERVE: begin
                        res_status_ff <= 1'b1;
                        state_ff      <= run_ok ? S_RD : S_OUT;
                     end
                     default: begin
                        res_status_ff <= 1'b1;
                        state_ff      <= S_OUT;
                     end
                  endcase
               end
            end
            S_GET: begin
               res_status_ff  <= 1'b0;
               res_handler_ff <= rd_handler_ff;
               res_state_ff   <= rd_state_ff;
               state_ff       <= S_OUT;
            end
            S_RD: begin
               // read issued at base + cnt while the run still fits
               state_ff <= scan_fits ? S_CMP : S_OUT;
            end
            S_CMP: begin
               if (entry_free) begin
                  if (cnt_ff + RUN_W'(1) == n_ff) begin
                     cnt_ff   <= '0;
                     state_ff <= S_MARK;
                  end else begin
                     cnt_ff   <= cnt_ff + RUN_W'(1);
                     state_ff <= S_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     base_ff <= base_ff + BW'(1);
                  end else if (aligned_ff) begin
                     base_ff <= base_ff + BW'(n_ff);
                  end else begin
                     base_ff <= base_ff + BW'(cnt_ff);
                  end
                  cnt_ff   <= '0;
                  state_ff <= S_RD;
               end
            end
            S_MARK: begin
               // one reserved marker written per cycle over the run
               if (cnt_ff + RUN_W'(1) == n_ff) begin
                  res_status_ff <= 1'b0;
                  res_first_ff  <= IDX_W'(base_ff);
                  state_ff      <= S_OUT;
               end else begin
                  cnt_ff <= cnt_ff + RUN_W'(1);
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'b0, res_first_ff, res_state_ff,
                                   res_handler_ff, res_status_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // run marking never leaves the table
   a_mark_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (scan_pos < BW'(TABLE_ENTRIES)))
      else $error("run marking outside the table");

   // run counter stays below the requested length while comparing
   a_cnt_below_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (cnt_ff < n_ff))
      else $error("run counter reached run length in compare");

   // a result leaving the holding registers lands in the output register
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded into output register");

   // memory writes only from assign or run marking
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we_in |-> (state_ff == S_MARK || (req_fire && req_tuser == REQ_ASSIGN)))
      else $error("unexpected handler memory write");

endmodule

`default_nettype wire

@@ tb/tb_vector_table_range_allocator_unit.sv @@
// ---------------------------------------------------------------------------
// tb_vector_table_range_allocator_unit: self-checking bench for the allocator
// Fills the vector table, runs directed edge requests, then random assign,
// get, reserve and unused-kind traffic over several marker settings. A shadow table
// predicts every response; stalls and idle gaps hit both stream sides.
// ---------------------------------------------------------------------------
module tb_vector_table_range_allocator_unit
   import vtra_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned     TBL_N       = 256;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int unsigned     TAIL_CYCLES = 600;

   typedef struct {
      logic [TYPE_W-1:0] kind;
      logic [IDX_W-1:0]  index;
      logic [WORD_W-1:0] handler;
      logic [WORD_W-1:0] state;
      logic [RUN_W-1:0]  count;
      logic              aligned;
   } vec_req_type;

   typedef struct {
      logic              status;
      logic [WORD_W-1:0] handler;
      logic [WORD_W-1:0] state;
      logic [IDX_W-1:0]  first;
   } vec_rsp_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [TYPE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic                  csr_addr   = 1'b0;
   logic [WORD_W-1:0]     csr_wdata  = '0;

   // shadow copy of the table and markers
   logic [WORD_W-1:0] shadow_handler [TBL_N];
   logic [WORD_W-1:0] shadow_state   [TBL_N];
   logic [WORD_W-1:0] free_mk = '0;
   logic [WORD_W-1:0] resv_mk = '0;

   vec_req_type vector_requests[$];
   vec_rsp_type answer_queue[$];
   bit          idle_on    = 1'b0;
   int unsigned err_count  = 0;

   vector_table_range_allocator_unit #(
      .TABLE_ENTRIES(TBL_N)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle gap length: mostly none or short, now and then long
   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // random handler that is neither zero nor the free marker
   function automatic logic [WORD_W-1:0] busy_word();
      logic [WORD_W-1:0] w;
      w = rand_word();
      while (w == '0 || w == free_mk) w = rand_word();
      return w;
   endfunction

   // first-fit search from the start vector; marks the run on success
   function automatic bit claim_run(int unsigned n, bit aligned, output int unsigned first);
      int unsigned pos;
      int unsigned span;
      int unsigned k;
      first = 0;
      if (n == 0 || n > MAX_RUN) return 1'b0;
      pos = SEARCH_START;
      while (pos + n <= TBL_N) begin
         if (shadow_handler[pos] == free_mk) begin
            span = 0;
            while (span < n && shadow_handler[pos + span] == free_mk) span++;
            if (span == n) begin
               for (k = 0; k < n; k++) shadow_handler[pos + k] = resv_mk;
               first = pos;
               return 1'b1;
            end
            pos += aligned ? n : span;
         end else begin
            pos++;
         end
      end
      return 1'b0;
   endfunction

   // expected response of one accepted request, updating the shadow table
   function automatic vec_rsp_type serve_request(vec_req_type rq);
      vec_rsp_type rs;
      int unsigned first;
      rs.status  = 1'b1;
      rs.handler = '0;
      rs.state   = '0;
      rs.first   = '0;
      case (rq.kind)
         REQ_ASSIGN: begin
            if (rq.index < TBL_N && rq.handler != '0) begin
               shadow_handler[rq.index] = rq.handler;
               shadow_state[rq.index]   = rq.state;
               rs.status = 1'b0;
            end
         end
         REQ_GET: begin
            if (rq.index < TBL_N) begin
               rs.handler = shadow_handler[rq.index];
               rs.state   = shadow_state[rq.index];
               rs.status  = 1'b0;
            end
         end
         REQ_RESERVE: begin
            if (claim_run(rq.count, rq.aligned, first)) begin
               rs.status = 1'b0;
               rs.first  = first[IDX_W-1:0];
            end
         end
         default: ;
      endcase
      return rs;
   endfunction

   function automatic vec_req_type make_req(logic [TYPE_W-1:0] kind, int unsigned index,
                                            logic [WORD_W-1:0] handler,
                                            logic [WORD_W-1:0] state,
                                            int unsigned count, bit aligned);
      vec_req_type rq;
      rq.kind    = kind;
      rq.index   = index[IDX_W-1:0];
      rq.handler = handler;
      rq.state   = state;
      rq.count   = count[RUN_W-1:0];
      rq.aligned = aligned;
      return rq;
   endfunction

   // one random request; fields a kind ignores stay random
   function automatic vec_req_type random_req();
      vec_req_type rq;
      int unsigned r;
      r = $urandom_range(0, 99);
      rq = make_req(REQ_UNUSED, $urandom_range(0, 511), rand_word(), rand_word(),
                    $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 90) rq.index[IDX_W-1] = 1'b0;
      if (r < 45) begin
         rq.kind = REQ_ASSIGN;
         r = $urandom_range(0, 99);
         if (r < 35)      rq.handler = free_mk;
         else if (r < 45) rq.handler = resv_mk;
         else if (r < 50) rq.handler = '0;
         else if (r < 55) rq.handler = '1;
      end else if (r < 70) begin
         rq.kind = REQ_GET;
      end else if (r < 93) begin
         rq.kind = REQ_RESERVE;
         r = $urandom_range(0, 99);
         if (r < 4)       rq.count = '0;
         else if (r < 8)  rq.count = RUN_W'($urandom_range(MAX_RUN + 1, 63));
         else if (r < 70) rq.count = RUN_W'($urandom_range(1, 6));
         else if (r < 90) rq.count = RUN_W'($urandom_range(7, 16));
         else             rq.count = RUN_W'($urandom_range(17, MAX_RUN));
      end
      return rq;
   endfunction

   // random traffic, partly releases of a range followed by a reserve
   task automatic queue_random(int unsigned cnt);
      int unsigned made;
      int unsigned start;
      int unsigned len;
      int unsigned k;
      made = 0;
      while (made < cnt) begin
         if ($urandom_range(0, 99) < 8) begin
            start = $urandom_range(SEARCH_START, TBL_N - 1);
            len   = $urandom_range(1, MAX_RUN);
            if (start + len > TBL_N) len = TBL_N - start;
            for (k = 0; k < len; k++) begin
               vector_requests.push_back(make_req(REQ_ASSIGN, start + k, free_mk, rand_word(),
                                                  $urandom_range(0, 63),
                                                  1'($urandom_range(0, 1))));
            end
            vector_requests.push_back(make_req(REQ_RESERVE, $urandom_range(0, 511), rand_word(),
                                               rand_word(), $urandom_range(1, len),
                                               1'($urandom_range(0, 1))));
            made += len + 1;
         end else begin
            vector_requests.push_back(random_req());
            made++;
         end
      end
   endtask

   task automatic write_csr(logic addr, logic [WORD_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      if (addr == CSR_FREE_MARKER) free_mk = data;
      else                         resv_mk = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (vector_requests.size() != 0 || req_tvalid || answer_queue.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      vec_req_type        cur_req;
      int unsigned        req_gap;
      logic               offer;
      if (!reset) begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            answer_queue.push_back(serve_request(cur_req));
            offer   = 1'b0;
            req_gap = draw_gap();
         end
         if (!offer) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (vector_requests.size() != 0) begin
               cur_req   = vector_requests.pop_front();
               req_tdata <= {cur_req.aligned, cur_req.count, cur_req.state,
                             cur_req.handler, cur_req.index};
               req_tuser <= cur_req.kind;
               offer     = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin : watch_rsp
      vec_rsp_type want;
      vec_rsp_type got;
      int unsigned rsp_seen;
      int unsigned hold;
      int unsigned stall;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status  = rsp_tdata[0];
            got.handler = rsp_tdata[64:1];
            got.state   = rsp_tdata[128:65];
            got.first   = rsp_tdata[137:129];
            rsp_seen++;
            if (answer_queue.size() == 0) begin
               $error("response beat with no request outstanding");
               err_count++;
            end else begin
               want = answer_queue.pop_front();
               if (got.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                  err_count++;
               end
               if (got.handler !== want.handler) begin
                  $error("read_handler mismatch: expected %h, got %h",
                         want.handler, got.handler);
                  err_count++;
               end
               if (got.state !== want.state) begin
                  $error("read_state mismatch: expected %h, got %h", want.state, got.state);
                  err_count++;
               end
               if (got.first !== want.first) begin
                  $error("first_index mismatch: expected %0d, got %0d", want.first, got.first);
                  err_count++;
               end
            end
            // long back-pressure so the block fills and stalls its input
            if (rsp_seen == 300 || rsp_seen == 900) hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall = draw_gap();
         end
      end
   end

   // stimulus and phase control
   initial begin : stimulus
      int unsigned i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // table fill: every entry written before any read
      write_csr(CSR_FREE_MARKER, busy_word());
      write_csr(CSR_RESERVED_MARKER, rand_word());
      @(negedge clock);
      for (i = 0; i < TBL_N; i++) begin
         // a busy entry every 16 vectors keeps a full-size run from fitting at first
         vector_requests.push_back(make_req(REQ_ASSIGN, i,
            ((i >= SEARCH_START && i % 16 == 15) || $urandom_range(0, 99) >= 75) ?
               busy_word() : free_mk,
            rand_word(), 0, 1'b0));
      end

      // directed edge cases
      vector_requests.push_back(make_req(REQ_ASSIGN, 0, '1, '0, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_ASSIGN, TBL_N - 1, 64'd1, '1, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_ASSIGN, TBL_N, '1, '1, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_ASSIGN, 511, '1, '1, 63, 1'b1));
      vector_requests.push_back(make_req(REQ_ASSIGN, 7, '0, '1, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_GET, 0, '0, '0, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_GET, TBL_N - 1, '0, '0, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_GET, TBL_N, '0, '0, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_GET, 511, '0, '0, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_GET, 7, '0, '0, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, MAX_RUN + 1, 1'b1));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, 63, 1'b0));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, MAX_RUN, 1'b0));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, MAX_RUN, 1'b1));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, 1, 1'b0));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, 1, 1'b1));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, 5, 1'b1));
      vector_requests.push_back(make_req(REQ_RESERVE, 0, '0, '0, 15, 1'b0));
      vector_requests.push_back(make_req(REQ_UNUSED, 511, '1, '1, 63, 1'b1));
      vector_requests.push_back(make_req(REQ_UNUSED, 0, '0, '0, 0, 1'b0));
      vector_requests.push_back(make_req(REQ_GET, SEARCH_START, '0, '0, 0, 1'b0));
      wait_drained();

      // random phases over several marker settings
      idle_on = 1'b1;
      write_csr(CSR_FREE_MARKER, '1);
      write_csr(CSR_RESERVED_MARKER, '0);
      @(negedge clock);
      queue_random(225);
      wait_drained();

      // zero free marker: only runs reserved with a zero marker are free
      idle_on = 1'b0;
      write_csr(CSR_FREE_MARKER, '0);
      write_csr(CSR_RESERVED_MARKER, rand_word());
      @(negedge clock);
      queue_random(225);
      wait_drained();

      idle_on = 1'b1;
      write_csr(CSR_FREE_MARKER, rand_word());
      write_csr(CSR_RESERVED_MARKER, '1);
      @(negedge clock);
      queue_random(225);
      wait_drained();

      write_csr(CSR_FREE_MARKER, 64'd1);
      write_csr(CSR_RESERVED_MARKER, rand_word());
      @(negedge clock);
      queue_random(225);
      wait_drained();

      idle_on = 1'b0;
      write_csr(CSR_FREE_MARKER, rand_word());
      write_csr(CSR_RESERVED_MARKER, rand_word());
      @(negedge clock);
      queue_random(225);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && answer_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #100ms;
      $display("simulation failed");
      $finish;
   end

endmodule
